### src/point_perspective_project_assert.svh
// Assertion macros shared by the projection block.
`ifndef POINT_PERSPECTIVE_PROJECT_ASSERT_SVH
`define POINT_PERSPECTIVE_PROJECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ppp_pkg.sv
// Shared widths, constants and types of the projection block.
package ppp_pkg;

    localparam int COORD_W  = 32;
    localparam int NUM_REGS = 8;
    localparam int REG_W    = 64;
    localparam int ADDR_W   = 6;
    localparam int SX_W     = 27;
    localparam int SY_W     = 26;
    localparam int DEPTH_W  = 32;

    localparam int TERM_W   = 61;
    localparam int PAIR_W   = 62;
    localparam int CLIP_W   = 63;
    localparam int DEN_W    = 64;
    localparam int DIV_Q    = 32;
    localparam int DIV_NW   = DEN_W + DIV_Q;

    localparam logic [CLIP_W-1:0] W_MIN     = CLIP_W'(512);
    localparam logic [DIV_Q-1:0]  SX_MAX    = 32'h07FF_FFFF;
    localparam logic [DIV_Q-1:0]  SY_MAX    = 32'h03FF_FFFF;
    localparam logic [DIV_Q-1:0]  DEP_POS   = 32'h7FFF_FFFF;
    localparam logic [DIV_Q-1:0]  DEP_NEG   = 32'h8000_0000;

    localparam logic [REG_W-1:0] MAT_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic vis;
        logic neg;
        logic ovf;
    } t_side;

endpackage

### src/ppp_if.sv
// Valid/ready channel interfaces for points in and projected results out.
interface ppp_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ppp_pkg::COORD_W-1:0]  point_x;
    logic signed [ppp_pkg::COORD_W-1:0]  point_y;
    logic signed [ppp_pkg::COORD_W-1:0]  point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

interface ppp_out_if;
    logic                                valid;
    logic                                ready;
    logic                                visible;
    logic [ppp_pkg::SX_W-1:0]            screen_x;
    logic [ppp_pkg::SY_W-1:0]            screen_y;
    logic signed [ppp_pkg::DEPTH_W-1:0]  depth;

    modport source (output valid, output visible, output screen_x, output screen_y,
                    output depth, input ready);
    modport sink (input valid, input visible, input screen_x, input screen_y,
                  input depth, output ready);
endinterface

### src/ppp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ppp_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ppp_pkg::DIV_NW-1:0]   i_num,
    input  logic [ppp_pkg::DEN_W-1:0]    i_den,
    output logic [ppp_pkg::DIV_Q-1:0]    o_quo
);
    localparam int Q  = ppp_pkg::DIV_Q;
    localparam int DW = ppp_pkg::DEN_W;

    logic [DW-1:0] r_rem [Q-1];
    logic [Q-1:0]  r_low [Q-1];
    logic [DW-1:0] r_den [Q-1];
    logic [Q-1:0]  r_quo [Q];

    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [Q-1:0]  low_in;
        logic [Q-1:0]  quo_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;

        if (k == 0) begin : g_first
            assign rem_in = i_num[ppp_pkg::DIV_NW-1:Q];
            assign low_in = i_num[Q-1:0];
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
        end

        assign trial = {rem_in, low_in[Q-1]};
        assign diff  = trial - {1'b0, den_in};

        // Borrow out of the trial subtract means the bit is zero: keep the trial.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {quo_in[Q-2:0], ~diff[DW]};
            end
        end

        if (k < Q - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
                    r_low[k] <= {low_in[Q-2:0], 1'b0};
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[Q-1];
endmodule

### src/point_perspective_project.sv
// Top level: perspective projection of world points to viewport pixels.
//
// Usage: points arrive on i_pt (valid/ready, x/y/z signed Q16.16); each transfer
// yields exactly one result on o_res: visible flag, pixel x/y (unsigned Q16.16,
// y downward) and depth (cz/w+1)/2 in signed Q16.16, saturating. Invisible
// points (|w| < 2^-20 or outside the [-1,1] square) return all-zero fields.
// The 4x4 matrix sits in eight 64-bit APB registers at byte address 8*i, two
// Q16.16 coefficients each; write it only while no point is in flight.
// Pipeline: 6 stages of multiply, add tree and compare, 32 stages of the
// three parallel dividers, one output register. Throughput: one point per
// cycle while no result waits untaken; the quotient pipelines retire one
// bit each per stage, so nothing iterates.
// Reset: clears all pipeline valid bits and loads the identity matrix; no
// clearing pass, the block takes points on the first cycle after reset.
// Stall: while a result waits untaken the whole pipeline holds in place and
// i_pt.ready drops; no item is lost or repeated.
`include "point_perspective_project_assert.svh"

module point_perspective_project #(
    parameter int unsigned SCREEN_WIDTH  = 1024,
    parameter int unsigned SCREEN_HEIGHT = 768
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppp_pkg::ADDR_W-1:0]     paddr,
    input  logic [ppp_pkg::REG_W-1:0]      pwdata,
    output logic [ppp_pkg::REG_W-1:0]      prdata,
    output logic                           pready,
    ppp_in_if.sink                         i_pt,
    ppp_out_if.source                      o_res
);
    localparam int CW  = ppp_pkg::COORD_W;
    localparam int TW  = ppp_pkg::TERM_W;
    localparam int PW  = ppp_pkg::PAIR_W;
    localparam int KW  = ppp_pkg::CLIP_W;
    localparam int DW  = ppp_pkg::DEN_W;
    localparam int NW  = ppp_pkg::DIV_NW;
    localparam int Q   = ppp_pkg::DIV_Q;
    localparam int WXW = $clog2(SCREEN_WIDTH + 1);
    localparam int WYW = $clog2(SCREEN_HEIGHT + 1);

    // ---------------- matrix registers (APB) ----------------
    logic [ppp_pkg::REG_W-1:0] r_mat [ppp_pkg::NUM_REGS];

    assign pready = 1'b1;
    assign prdata = r_mat[paddr[5:3]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= ppp_pkg::MAT_RESET;
        end else if (psel && penable && pwrite) begin
            r_mat[paddr[5:3]] <= pwdata;
        end
    end

    logic signed [CW-1:0] coef [4][4];
    logic signed [CW-1:0] xv   [3];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            coef[r][0] = r_mat[3'(2 * r)][31:0];
            coef[r][1] = r_mat[3'(2 * r)][63:32];
            coef[r][2] = r_mat[3'(2 * r + 1)][31:0];
            coef[r][3] = r_mat[3'(2 * r + 1)][63:32];
        end
        xv[0] = i_pt.point_x;
        xv[1] = i_pt.point_y;
        xv[2] = i_pt.point_z;
    end

    // ---------------- pipeline control ----------------
    // One global enable: every stage advances unless a result waits untaken.
    logic         r_ov;
    logic         en;
    logic [5:0]   r_v;
    logic [Q-1:0] r_dv;

    assign en         = !r_ov || o_res.ready;
    assign i_pt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[4:0], i_pt.valid};
            r_dv <= {r_dv[Q-2:0], r_v[5]};
            r_ov <= r_dv[Q-1];
        end
    end

    // ---------------- S1: products, floor-shifted to Q32.29 ----------------
    logic signed [63:0]   prod [4][3];
    logic signed [TW-1:0] r_t1 [4][3];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod[r][c] = coef[r][c] * xv[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_t1[r][c] <= TW'(prod[r][c] >>> 3);
                end
            end
        end
    end

    // ---------------- S2/S3: row sums; the w=1 column is coef << 13 ----------------
    logic signed [PW-1:0] r_a2 [4];
    logic signed [PW-1:0] r_b2 [4];
    logic signed [KW-1:0] r_c3 [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                r_a2[r] <= PW'(r_t1[r][0]) + PW'(r_t1[r][1]);
                r_b2[r] <= PW'(r_t1[r][2]) + (PW'(coef[r][3]) <<< 13);
                r_c3[r] <= KW'(r_a2[r]) + KW'(r_b2[r]);
            end
        end
    end

    // ---------------- S4: magnitudes and numerator sums ----------------
    logic signed [KW-1:0] cx, cy, cz, cw;
    logic [KW-1:0]        r_aw4, r_acx4, r_acy4;
    logic signed [63:0]   r_sx4, r_sy4, r_sd4;
    logic                 r_wneg4;

    assign cx = r_c3[0];
    assign cy = r_c3[1];
    assign cz = r_c3[2];
    assign cw = r_c3[3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_aw4   <= cw[KW-1] ? KW'(-cw) : KW'(cw);
            r_acx4  <= cx[KW-1] ? KW'(-cx) : KW'(cx);
            r_acy4  <= cy[KW-1] ? KW'(-cy) : KW'(cy);
            r_sx4   <= 64'(cx) + 64'(cw);
            r_sy4   <= 64'(cw) - 64'(cy);
            r_sd4   <= 64'(cz) + 64'(cw);
            r_wneg4 <= cw[KW-1];
        end
    end

    // ---------------- S5: screen test, divisor, depth sign ----------------
    logic          r_vis5, r_neg5;
    logic [DW-1:0] r_den5, r_nx5, r_ny5, r_nd5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vis5 <= (r_aw4 >= ppp_pkg::W_MIN) && (r_acx4 <= r_aw4) && (r_acy4 <= r_aw4);
            r_den5 <= {r_aw4, 1'b0};
            r_nx5  <= r_sx4[63] ? DW'(-r_sx4) : DW'(r_sx4);
            r_ny5  <= r_sy4[63] ? DW'(-r_sy4) : DW'(r_sy4);
            r_nd5  <= r_sd4[63] ? DW'(-r_sd4) : DW'(r_sd4);
            r_neg5 <= (r_sd4 != '0) && (r_sd4[63] != r_wneg4);
        end
    end

    // ---------------- S6: scale numerators, flag depth overflow ----------------
    logic [DW+WXW-1:0] mx;
    logic [DW+WYW-1:0] my;
    logic              dovf;
    logic [NW-1:0]     r_nx6, r_ny6, r_nd6;
    logic [DW-1:0]     r_den6;
    ppp_pkg::t_side    r_sd6;

    assign mx   = (DW + WXW)'(r_nx5) * (DW + WXW)'(SCREEN_WIDTH);
    assign my   = (DW + WYW)'(r_ny5) * (DW + WYW)'(SCREEN_HEIGHT);
    // Quotient of (nd << 16) / den reaches 2^32 exactly when nd >= den << 16.
    assign dovf = {16'b0, r_nd5} >= {r_den5, 16'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx6  <= NW'({mx, 16'b0});
            r_ny6  <= NW'({my, 16'b0});
            r_nd6  <= dovf ? '0 : NW'({r_nd5, 16'b0});
            r_den6 <= r_den5;
            r_sd6  <= '{vis: r_vis5, neg: r_neg5, ovf: dovf};
        end
    end

    // ---------------- dividers and sideband delay line ----------------
    logic [Q-1:0]   qx, qy, qd;
    ppp_pkg::t_side r_sb [Q];

    ppp_div u_div_x (.i_clk(i_clk), .i_en(en), .i_num(r_nx6), .i_den(r_den6), .o_quo(qx));
    ppp_div u_div_y (.i_clk(i_clk), .i_en(en), .i_num(r_ny6), .i_den(r_den6), .o_quo(qy));
    ppp_div u_div_d (.i_clk(i_clk), .i_en(en), .i_num(r_nd6), .i_den(r_den6), .o_quo(qd));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= r_sd6;
            for (int k = 1; k < Q; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // ---------------- output: saturate, zero invisible points ----------------
    ppp_pkg::t_side               sb;
    logic [Q-1:0]                 sx, sy, dm, dep;
    logic                         r_vis;
    logic [ppp_pkg::SX_W-1:0]     r_sx;
    logic [ppp_pkg::SY_W-1:0]     r_sy;
    logic [ppp_pkg::DEPTH_W-1:0]  r_dep;

    assign sb = r_sb[Q-1];

    always_comb begin
        sx = (qx > ppp_pkg::SX_MAX) ? ppp_pkg::SX_MAX : qx;
        sy = (qy > ppp_pkg::SY_MAX) ? ppp_pkg::SY_MAX : qy;
        if (!sb.neg) begin
            dm  = (sb.ovf || qd > ppp_pkg::DEP_POS) ? ppp_pkg::DEP_POS : qd;
            dep = dm;
        end else begin
            dm  = (sb.ovf || qd > ppp_pkg::DEP_NEG) ? ppp_pkg::DEP_NEG : qd;
            dep = -dm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vis <= sb.vis;
            r_sx  <= sb.vis ? sx[ppp_pkg::SX_W-1:0] : '0;
            r_sy  <= sb.vis ? sy[ppp_pkg::SY_W-1:0] : '0;
            r_dep <= sb.vis ? dep : '0;
        end
    end

    assign o_res.valid    = r_ov;
    assign o_res.visible  = r_vis;
    assign o_res.screen_x = r_sx;
    assign o_res.screen_y = r_sy;
    assign o_res.depth    = r_dep;

    // ---------------- assertions ----------------
    `PPP_ASSERT_IMPLY(a_invis_zero, i_clk, i_rst_n, o_res.valid && !o_res.visible, o_res.screen_x == '0 && o_res.screen_y == '0 && o_res.depth == '0, "invisible point has nonzero fields")
    `PPP_ASSERT_IMPLY(a_sx_range, i_clk, i_rst_n, o_res.valid && o_res.visible, (33'(o_res.screen_x) <= (33'(SCREEN_WIDTH) << 16)) && (33'(o_res.screen_y) <= (33'(SCREEN_HEIGHT) << 16)), "pixel coordinate beyond screen")
    `PPP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_ov && !o_res.ready, r_dv == $past(r_dv) && r_v == $past(r_v), "pipeline moved during stall")
endmodule

### tb/point_perspective_project_tb.sv
// Self-checking testbench for the point perspective projection block.
`timescale 1ns / 1ps

module point_perspective_project_tb;

    localparam int unsigned SCR_W   = 1024;
    localparam int unsigned SCR_H   = 768;
    localparam int          LATENCY = 39;

    // Matrix register indexes, in order of the register map.
    typedef enum int {
        R0_C01, R0_C23, R1_C01, R1_C23, R2_C01, R2_C23, R3_C01, R3_C23
    } t_mat_reg;

    // Stimulus flavors of one phase.
    typedef enum int {
        M_RANDOM, M_PERSP, M_ZERO, M_ONES, M_WSMALL, M_SIGNS
    } t_phase_mode;

    typedef struct packed {
        logic signed [ppp_pkg::COORD_W-1:0] x;
        logic signed [ppp_pkg::COORD_W-1:0] y;
        logic signed [ppp_pkg::COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic                               vis;
        logic [ppp_pkg::SX_W-1:0]           sx;
        logic [ppp_pkg::SY_W-1:0]           sy;
        logic signed [ppp_pkg::DEPTH_W-1:0] depth;
    } t_proj;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ppp_pkg::ADDR_W-1:0] paddr = '0;
    logic [ppp_pkg::REG_W-1:0]  pwdata = '0;
    logic [ppp_pkg::REG_W-1:0]  prdata;
    logic                       pready;

    ppp_in_if  pt_if ();
    ppp_out_if res_if ();

    point_perspective_project #(.SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_pt(pt_if), .o_res(res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [ppp_pkg::REG_W-1:0] mat_shadow [ppp_pkg::NUM_REGS];
    t_point pending_pts [$];
    t_proj  expected_proj [$];
    int     err_cnt = 0;
    int     accepted_pts = 0;
    bit     in_took = 1'b0;
    bit     quiet = 1'b0;
    bit     running = 1'b0;
    int     in_gap = 0;
    int     out_hold = 0;
    bit     pressure_done = 1'b0;

    initial begin
        pt_if.valid = 1'b0;
        pt_if.point_x = '0;
        pt_if.point_y = '0;
        pt_if.point_z = '0;
        res_if.ready = 1'b0;
        for (int i = 0; i < ppp_pkg::NUM_REGS; i++) mat_shadow[i] = ppp_pkg::MAT_RESET[i];
    end

    // Fetch coefficient (row, col) of the shadow matrix, sign-extended.
    function automatic longint coef_of(int row, int col);
        logic [63:0] r;
        r = mat_shadow[row * 2 + col / 2];
        return (col % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
    endfunction

    // floor(num * m / den), capped at 2^62.
    function automatic logic [63:0] scaled_div(logic [63:0] num, logic [63:0] den,
                                               logic [63:0] m);
        logic [127:0] q;
        q = ({64'b0, num} * {64'b0, m}) / {64'b0, den};
        if (q > (128'd1 << 62)) q = 128'd1 << 62;
        return q[63:0];
    endfunction

    function automatic logic [63:0] mag(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Project one world point with the current shadow matrix.
    function automatic t_proj project_point(t_point p);
        longint v [4];
        longint clip [4];
        longint w, s;
        logic [63:0] aw, den, sx, sy, dm;
        bit neg;
        t_proj r;
        v[0] = longint'(p.x);
        v[1] = longint'(p.y);
        v[2] = longint'(p.z);
        v[3] = 65536;
        for (int i = 0; i < 4; i++) begin
            clip[i] = 0;
            for (int j = 0; j < 4; j++) clip[i] += (coef_of(i, j) * v[j]) >>> 3;
        end
        r = '0;
        w = clip[3];
        aw = mag(w);
        // near-zero w and off-screen points give an all-zero result
        if (aw < 64'd512) return r;
        if (mag(clip[0]) > aw || mag(clip[1]) > aw) return r;
        den = aw * 2;
        sx = scaled_div(mag(clip[0] + w), den, 64'(SCR_W) << 16);
        if (sx > 64'h7FF_FFFF) sx = 64'h7FF_FFFF;
        sy = scaled_div(mag(w - clip[1]), den, 64'(SCR_H) << 16);
        if (sy > 64'h3FF_FFFF) sy = 64'h3FF_FFFF;
        s = clip[2] + w;
        neg = (s != 0) && ((s < 0) != (w < 0));
        dm = scaled_div(mag(s), den, 64'd65536);
        if (!neg) begin
            if (dm > 64'h7FFF_FFFF) dm = 64'h7FFF_FFFF;
            r.depth = dm[31:0];
        end else begin
            if (dm > 64'h8000_0000) dm = 64'h8000_0000;
            r.depth = 32'(-dm);
        end
        r.vis = 1'b1;
        r.sx = sx[ppp_pkg::SX_W-1:0];
        r.sy = sy[ppp_pkg::SY_W-1:0];
        return r;
    endfunction

    // APB write: setup cycle, then access cycle; the register lands at the access edge.
    task automatic mat_write(t_mat_reg idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ppp_pkg::ADDR_W'(int'(idx) * 8);
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        mat_shadow[idx] = val;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] q16(int v);
        return 32'(v) << 16;
    endfunction

    function automatic logic [63:0] pack2(logic [31:0] lo, logic [31:0] hi);
        return {hi, lo};
    endfunction

    function automatic logic [31:0] rnd_small(int lim);
        return 32'($signed($urandom_range(0, 2 * lim)) - lim);
    endfunction

    // Load all eight registers for one phase.
    task automatic load_matrix(t_phase_mode mode);
        logic [63:0] m [ppp_pkg::NUM_REGS];
        case (mode)
            M_RANDOM: begin
                for (int i = 0; i < ppp_pkg::NUM_REGS; i++) m[i] = {$urandom, $urandom};
            end
            M_PERSP: begin
                m[R0_C01] = pack2(rnd_small(3 << 16), 32'h0);
                m[R0_C23] = 64'h0;
                m[R1_C01] = pack2(32'h0, rnd_small(3 << 16));
                m[R1_C23] = 64'h0;
                m[R2_C01] = 64'h0;
                m[R2_C23] = pack2(rnd_small(2 << 16), rnd_small(4 << 16));
                m[R3_C01] = 64'h0;
                m[R3_C23] = pack2(($urandom_range(0, 1)) ? 32'hFFFF_0000 : q16(1), 32'h0);
            end
            M_ZERO: begin
                for (int i = 0; i < ppp_pkg::NUM_REGS; i++) m[i] = 64'h0;
            end
            M_ONES: begin
                for (int i = 0; i < ppp_pkg::NUM_REGS; i++) m[i] = '1;
            end
            M_WSMALL: begin
                // w depends on z at the smallest step, straddling the near-zero bound
                m[R0_C01] = pack2(rnd_small(16), rnd_small(4));
                m[R0_C23] = pack2(rnd_small(4), 32'h0);
                m[R1_C01] = pack2(rnd_small(4), rnd_small(16));
                m[R1_C23] = pack2(rnd_small(4), 32'h0);
                m[R2_C01] = 64'h0;
                m[R2_C23] = pack2(q16(($urandom_range(0, 1)) ? 2000 : -2000), rnd_small(64));
                m[R3_C01] = 64'h0;
                m[R3_C23] = pack2(($urandom_range(0, 1)) ? 32'h1 : 32'hFFFF_FFFF, 32'h0);
            end
            default: begin
                for (int i = 0; i < ppp_pkg::NUM_REGS; i++)
                    m[i] = ($urandom_range(0, 1)) ? 64'h7FFF_FFFF_8000_0000
                                                  : 64'h8000_0000_7FFF_FFFF;
            end
        endcase
        for (int i = 0; i < ppp_pkg::NUM_REGS; i++) mat_write(t_mat_reg'(i), m[i]);
    endtask

    // Queue n points shaped for the phase's matrix.
    task automatic queue_points(t_phase_mode mode, int n);
        t_point p;
        int zi;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                p = {$urandom, $urandom, $urandom};
            end else if (mode == M_PERSP) begin
                zi = $urandom_range(1 << 12, 100 << 16);
                p.z = ($urandom_range(0, 1)) ? 32'(-zi) : 32'(zi);
                p.x = rnd_small(zi / 2);
                p.y = rnd_small(zi / 2);
            end else if (mode == M_WSMALL) begin
                p.x = rnd_small(1 << 16);
                p.y = rnd_small(1 << 16);
                p.z = rnd_small(1 << 14);
            end else begin
                p.x = rnd_small(4 << 16);
                p.y = rnd_small(4 << 16);
                p.z = rnd_small(4 << 16);
            end
            pending_pts.push_back(p);
        end
    endtask

    task automatic drain;
        @(posedge i_clk);
        while (pending_pts.size() != 0 || pt_if.valid || expected_proj.size() != 0)
            @(posedge i_clk);
    endtask

    // Monitor: predict on input transfers, check on output transfers.
    always @(posedge i_clk) begin
        t_proj got, exp_r;
        in_took = i_rst_n && pt_if.valid && pt_if.ready;
        if (in_took) begin
            expected_proj.push_back(project_point({pt_if.point_x, pt_if.point_y,
                                                   pt_if.point_z}));
            accepted_pts++;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.visible, res_if.screen_x, res_if.screen_y, res_if.depth};
            if (expected_proj.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                err_cnt++;
            end else begin
                exp_r = expected_proj.pop_front();
                if (got.vis !== exp_r.vis) begin
                    $display("%0t: visible exp %b got %b", $time, exp_r.vis, got.vis);
                    err_cnt++;
                end
                if (got.sx !== exp_r.sx) begin
                    $display("%0t: screen_x exp %h got %h", $time, exp_r.sx, got.sx);
                    err_cnt++;
                end
                if (got.sy !== exp_r.sy) begin
                    $display("%0t: screen_y exp %h got %h", $time, exp_r.sy, got.sy);
                    err_cnt++;
                end
                if (got.depth !== exp_r.depth) begin
                    $display("%0t: depth exp %h got %h", $time, exp_r.depth, got.depth);
                    err_cnt++;
                end
            end
        end
    end

    // Driver: hold a point until its transfer, then insert a gap or advance.
    always @(negedge i_clk) begin
        logic nv;
        t_point p;
        nv = pt_if.valid && !in_took;
        if (running && !nv) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(0, 12);
            end else if (pending_pts.size() != 0) begin
                p = pending_pts.pop_front();
                pt_if.point_x <= p.x;
                pt_if.point_y <= p.y;
                pt_if.point_z <= p.z;
                nv = 1'b1;
            end
        end
        pt_if.valid <= nv;
    end

    // Receiver: random stalls, plus one long hold-off to back up the pipeline.
    always @(negedge i_clk) begin
        logic nr;
        nr = 1'b1;
        if (!running) begin
            nr = 1'b0;
        end else if (out_hold > 0) begin
            out_hold--;
            nr = 1'b0;
        end else if (!pressure_done && accepted_pts >= 60) begin
            pressure_done = 1'b1;
            out_hold = 300;
            nr = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_hold = $urandom_range(0, 12);
            nr = 1'b0;
        end
        res_if.ready <= nr;
    end

    initial begin
        t_phase_mode mode;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;

        // Directed points against the reset identity matrix.
        pending_pts.push_back({32'h0, 32'h0, 32'h0});
        pending_pts.push_back({q16(1), q16(1), q16(1)});
        pending_pts.push_back({q16(-1), q16(-1), q16(-1)});
        pending_pts.push_back({32'h0001_8000, 32'h0, 32'h0});
        pending_pts.push_back({32'h0, 32'hFFFE_8000, 32'h0});
        pending_pts.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        pending_pts.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        pending_pts.push_back({32'h0, 32'h0, 32'h7FFF_FFFF});
        pending_pts.push_back({32'h0, 32'h0, 32'h8000_0000});
        pending_pts.push_back({32'h0000_FFFF, 32'hFFFF_0001, 32'h0000_0001});
        pending_pts.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        drain();

        // Zero matrix: w is zero, every point invisible.
        load_matrix(M_ZERO);
        pending_pts.push_back({q16(1), q16(2), q16(3)});
        pending_pts.push_back({32'h0, 32'h0, 32'h0});
        drain();

        // Extreme coefficient patterns.
        load_matrix(M_ONES);
        pending_pts.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001});
        pending_pts.push_back({32'h0, 32'h0, 32'h0});
        drain();
        load_matrix(M_SIGNS);
        pending_pts.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        pending_pts.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        drain();

        // Random phases; mostly perspective and near-zero-w matrices.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0, 3: mode = M_PERSP;
                1, 4: mode = M_WSMALL;
                default: mode = M_RANDOM;
            endcase
            if (ph == 9) quiet = 1'b1;
            load_matrix(mode);
            queue_points(mode, 53);
            drain();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (err_cnt == 0 && expected_proj.size() == 0) begin
            $display("point_perspective_project_tb: clean");
        end else begin
            $display("point_perspective_project_tb: errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("point_perspective_project_tb: errors");
        $finish;
    end

endmodule
